/* design/sbd_pkg.sv */
package sbd_pkg;

   localparam int VALUE_W = 32;
   localparam int ENTRY_W = VALUE_W + 1;
   localparam int VALID_BIT = VALUE_W;

   localparam logic [VALUE_W-1:0] HASH_MULT = 32'h9E37_79B1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_CHECK
   } ctrl_state_type;

   typedef enum logic [2:0] {
      HASH_IDLE,
      HASH_MIX,
      HASH_QUOT,
      HASH_REM,
      HASH_FIX
   } hash_state_type;

endpackage

/* design/seen_before_detector_unit.sv */
// Duplicate detector over a stream of signed 32-bit values.
// Command channel: start with req_value is taken on an edge where busy is
// low. One transaction gives exactly one response, shown for a single cycle
// with rsp_valid: rsp_seen is 1 if the value arrived before, rsp_table_full
// is 1 if the value was new and no slot was left to hold it.
// Values live in a CAPACITY-slot hash table (linear probing) held in one
// single-port-read RAM whose words carry a valid bit and the value.
// Per transaction: the hash unit mixes the value; for a CAPACITY that is not
// a power of two it then reduces the mix modulo CAPACITY by reciprocal
// multiply (quotient, remainder, fix-up). Up to CAPACITY slots are then
// probed, one registered RAM read each, until a free slot, a match or the last.
// busy falls with rsp_valid, so the next value can be taken in that cycle.
// Reset starts a clearing pass over every slot, one slot a cycle, with
// busy held high; the set is empty afterwards.
// The receiver cannot stall: a response must be taken in its cycle.
module seen_before_detector_unit #(
   parameter int CAPACITY = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [sbd_pkg::VALUE_W-1:0]    req_value,
   output logic                                  rsp_valid,
   output logic                                  rsp_seen,
   output logic                                  rsp_table_full
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

   sbd_pkg::ctrl_state_type state_ff, state_in;

   logic [sbd_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic [SLOT_W-1:0]           probe_ff, probe_in;
   logic [SLOT_W-1:0]           clr_ff, clr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_seen_ff, rsp_seen_in;
   logic                        rsp_full_ff, rsp_full_in;

   logic                        accept;
   logic                        hash_done;
   logic [SLOT_W-1:0]           hash_slot;
   logic [SLOT_W-1:0]           slot_next;
   logic                        hit_free;
   logic                        hit_match;
   logic                        last_probe;

   logic                        wr_en;
   logic [SLOT_W-1:0]           wr_addr;
   logic [sbd_pkg::ENTRY_W-1:0] wr_data;
   logic                        rd_en;
   logic [SLOT_W-1:0]           rd_addr;
   logic [sbd_pkg::ENTRY_W-1:0] rd_data;

   assign busy   = (state_ff != sbd_pkg::ST_IDLE);
   assign accept = start && !busy;

   sbd_hash #(
      .CAPACITY(CAPACITY)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .value (req_value),
      .done  (hash_done),
      .slot  (hash_slot)
   );

   sbd_ram #(
      .WIDTH(sbd_pkg::ENTRY_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_next  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
   assign hit_free   = !rd_data[sbd_pkg::VALID_BIT];
   assign hit_match  = (rd_data[sbd_pkg::VALUE_W-1:0] == value_ff);
   assign last_probe = (probe_ff == LAST_SLOT);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbd_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_SLOT) begin
               state_in = sbd_pkg::ST_IDLE;
            end
         end
         sbd_pkg::ST_IDLE: begin
            if (start) begin
               state_in = sbd_pkg::ST_HASH;
            end
         end
         sbd_pkg::ST_HASH: begin
            if (hash_done) begin
               state_in = sbd_pkg::ST_PROBE;
            end
         end
         sbd_pkg::ST_PROBE: state_in = sbd_pkg::ST_CHECK;
         sbd_pkg::ST_CHECK: begin
            if (hit_free || hit_match || last_probe) begin
               state_in = sbd_pkg::ST_IDLE;
            end
         end
         default: state_in = sbd_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      value_in     = value_ff;
      slot_in      = slot_ff;
      probe_in     = probe_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_seen_in  = 1'b0;
      rsp_full_in  = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = {1'b1, value_ff};
      rd_en        = 1'b0;
      rd_addr      = slot_ff;
      unique case (state_ff)
         sbd_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
         end
         sbd_pkg::ST_IDLE: begin
            if (start) begin
               value_in = req_value;
            end
         end
         sbd_pkg::ST_HASH: begin
            slot_in  = hash_slot;
            probe_in = '0;
         end
         sbd_pkg::ST_PROBE: begin
            rd_en = 1'b1;
         end
         sbd_pkg::ST_CHECK: begin
            priority if (hit_free) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
            end else if (hit_match) begin
               rsp_valid_in = 1'b1;
               rsp_seen_in  = 1'b1;
            end else if (last_probe) begin
               rsp_valid_in = 1'b1;
               rsp_full_in  = 1'b1;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = slot_next;
               slot_in  = slot_next;
               probe_in = probe_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbd_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff    <= value_in;
      slot_ff     <= slot_in;
      probe_ff    <= probe_in;
      rsp_seen_ff <= rsp_seen_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_seen       = rsp_seen_ff;
   assign rsp_table_full = rsp_full_ff;

endmodule

/* design/sbd_ram.sv */
module sbd_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/sbd_hash.sv */
module sbd_hash #(
   parameter int CAPACITY = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [sbd_pkg::VALUE_W-1:0]       value,
   output logic                              done,
   output logic [$clog2(CAPACITY)-1:0]       slot
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
   localparam logic [63:0] RECIP_WIDE = (64'd1 << sbd_pkg::VALUE_W) / 64'(CAPACITY);
   localparam logic [sbd_pkg::VALUE_W-1:0] RECIP = RECIP_WIDE[sbd_pkg::VALUE_W-1:0];
   localparam logic [63:0] CAP_WIDE = 64'(CAPACITY);
   localparam logic [sbd_pkg::VALUE_W-1:0] CAP_W = CAP_WIDE[sbd_pkg::VALUE_W-1:0];

   sbd_pkg::hash_state_type state_ff, state_in;

   logic [sbd_pkg::VALUE_W-1:0]   prod_ff, prod_in;
   logic [sbd_pkg::VALUE_W-1:0]   mix_ff, mix_in;
   logic [sbd_pkg::VALUE_W-1:0]   quot_ff, quot_in;
   logic [SLOT_W:0]               rem_ff, rem_in;
   logic [SLOT_W-1:0]             slot_ff, slot_in;
   logic                          done_ff, done_in;

   logic [sbd_pkg::VALUE_W-1:0]   mixed;
   logic [2*sbd_pkg::VALUE_W-1:0] recip_prod;
   logic [sbd_pkg::VALUE_W-1:0]   quot_mul;
   logic [sbd_pkg::VALUE_W-1:0]   rem_wide;
   logic [SLOT_W:0]               reduced;

   // modulo by reciprocal: quotient estimate is at most one short
   always_comb begin
      mixed      = prod_ff ^ (prod_ff >> 16);
      recip_prod = {{sbd_pkg::VALUE_W{1'b0}}, mix_ff} * {{sbd_pkg::VALUE_W{1'b0}}, RECIP};
      quot_mul   = quot_ff * CAP_W;
      rem_wide   = mix_ff - quot_mul;
      if (rem_ff >= (SLOT_W+1)'(CAPACITY)) begin
         reduced = rem_ff - (SLOT_W+1)'(CAPACITY);
      end else begin
         reduced = rem_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbd_pkg::HASH_IDLE: begin
            if (start) begin
               state_in = sbd_pkg::HASH_MIX;
            end
         end
         sbd_pkg::HASH_MIX: begin
            state_in = IS_POW2 ? sbd_pkg::HASH_IDLE : sbd_pkg::HASH_QUOT;
         end
         sbd_pkg::HASH_QUOT: state_in = sbd_pkg::HASH_REM;
         sbd_pkg::HASH_REM:  state_in = sbd_pkg::HASH_FIX;
         sbd_pkg::HASH_FIX:  state_in = sbd_pkg::HASH_IDLE;
         default: state_in = sbd_pkg::HASH_IDLE;
      endcase
   end

   always_comb begin
      prod_in = prod_ff;
      mix_in  = mix_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      slot_in = slot_ff;
      done_in = 1'b0;
      unique case (state_ff)
         sbd_pkg::HASH_IDLE: begin
            if (start) begin
               prod_in = value * sbd_pkg::HASH_MULT;
            end
         end
         sbd_pkg::HASH_MIX: begin
            mix_in = mixed;
            if (IS_POW2) begin
               slot_in = mixed[SLOT_W-1:0];
               done_in = 1'b1;
            end
         end
         sbd_pkg::HASH_QUOT: begin
            quot_in = recip_prod[2*sbd_pkg::VALUE_W-1:sbd_pkg::VALUE_W];
         end
         sbd_pkg::HASH_REM: begin
            rem_in = rem_wide[SLOT_W:0];
         end
         sbd_pkg::HASH_FIX: begin
            slot_in = reduced[SLOT_W-1:0];
            done_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbd_pkg::HASH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      prod_ff <= prod_in;
      mix_ff  <= mix_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      slot_ff <= slot_in;
   end

   assign done = done_ff;
   assign slot = slot_ff;

endmodule

/* design/sbd_checker.sv */
module sbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_seen,
   input logic        rsp_table_full
);

   // a known duplicate is never reported as a lost insertion
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_seen && rsp_table_full))
      else $error("seen and table_full both set");

   // an accepted transaction makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after acceptance");

   // a response only closes a transaction that was in flight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a transaction in flight");

   // responses are single-cycle strobes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // reset starts the clearing pass
   assert property (@(posedge clock)
      reset |=> busy)
      else $error("not busy after reset");

endmodule

bind seen_before_detector_unit sbd_checker u_sbd_checker (.*);

/* verif/seen_before_checker.sv */
`timescale 1ns / 1ps

package sbd_tb_pkg;

   localparam logic [31:0] GOLDEN_MULT = 32'h9E37_79B1;

   function automatic int home_slot_of(input logic [31:0] v, input int capacity);
      logic [31:0] h;
      h = v * GOLDEN_MULT;
      h = h ^ (h >> 16);
      return int'(h % 32'(capacity));
   endfunction

endpackage

module seen_before_checker #(
   parameter int CAPACITY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_seen,
   input  logic        rsp_table_full,
   output int          fail_count,
   output int          pending,
   output int          answers,
   output int          repeats,
   output int          rejections
);

   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic seen;
      logic table_full;
   } answer_type;

   logic [31:0] slot_value [CAPACITY];
   bit          slot_taken [CAPACITY];
   answer_type  expected_answers[$];

   int mismatches = 0;
   int n_answers = 0;
   int n_repeats = 0;
   int n_rejections = 0;
   int n_pending = 0;

   assign fail_count = mismatches;
   assign pending    = n_pending;
   assign answers    = n_answers;
   assign repeats    = n_repeats;
   assign rejections = n_rejections;

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_CAP) begin
         $display("%0t ns: mismatch: %s", $realtime, what);
      end
      mismatches++;
   endtask

   // linear probe from the home slot; stores the value in the first free slot
   function automatic void probe_and_insert(input logic [31:0] v, output logic seen,
                                            output logic table_full);
      int slot;
      seen = 1'b0;
      table_full = 1'b1;
      slot = sbd_tb_pkg::home_slot_of(v, CAPACITY);
      for (int i = 0; i < CAPACITY; i++) begin
         if (!slot_taken[slot]) begin
            slot_taken[slot] = 1'b1;
            slot_value[slot] = v;
            table_full = 1'b0;
            return;
         end
         if (slot_value[slot] == v) begin
            seen = 1'b1;
            table_full = 1'b0;
            return;
         end
         slot = (slot + 1) % CAPACITY;
      end
   endfunction

   always @(posedge clock) begin
      answer_type want;
      answer_type due;
      if (reset) begin
         foreach (slot_taken[i]) slot_taken[i] = 1'b0;
         expected_answers.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               report_mismatch("response with no transaction outstanding");
            end else begin
               want = expected_answers.pop_front();
               n_answers++;
               if (want.seen) n_repeats++;
               if (want.table_full) n_rejections++;
               if (rsp_seen !== want.seen) begin
                  report_mismatch($sformatf("rsp_seen %b, expected %b (answer %0d)",
                                            rsp_seen, want.seen, n_answers));
               end
               if (rsp_table_full !== want.table_full) begin
                  report_mismatch($sformatf("rsp_table_full %b, expected %b (answer %0d)",
                                            rsp_table_full, want.table_full, n_answers));
               end
            end
         end
         if (start && !busy) begin
            probe_and_insert(req_value, due.seen, due.table_full);
            expected_answers = {expected_answers, due};
         end
      end
      n_pending = expected_answers.size();
   end

endmodule

/* verif/tb_seen_before_detector_unit.sv */
`timescale 1ns / 1ps

module tb_seen_before_detector_unit;

   localparam int CAPACITY = 1024;
   localparam int RANDOM_ITEMS = 1200;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic signed [31:0] req_value = '0;
   logic               busy;
   logic               rsp_valid;
   logic               rsp_seen;
   logic               rsp_table_full;

   int fail_count;
   int pending;
   int answers;
   int repeats;
   int rejections;

   bit          quiet = 1'b0;
   logic [31:0] history[$];
   bit          offered[logic [31:0]];

   always #4 clock = ~clock;

   seen_before_detector_unit #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_seen(rsp_seen),
      .rsp_table_full(rsp_table_full)
   );

   seen_before_checker #(
      .CAPACITY(CAPACITY)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_seen(rsp_seen),
      .rsp_table_full(rsp_table_full),
      .fail_count(fail_count),
      .pending(pending),
      .answers(answers),
      .repeats(repeats),
      .rejections(rejections)
   );

   task automatic send_value(input logic [31:0] v);
      start <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (busy);
      history = {history, v};
      offered[v] = 1'b1;
      if (!quiet && $urandom_range(0, 99) < 10) begin
         start <= 1'b0;
         req_value <= $urandom;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   initial begin
      #50_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [31:0] directed[$];
      logic [31:0] wrap_vals[$];
      logic [31:0] head_val;
      logic [31:0] cand;
      logic [31:0] pick;
      int          r;
      int          rep_pct;

      // values homed on the last slot (probe wraps round) and on slot zero
      cand = 32'd2;
      while (wrap_vals.size() < 3) begin
         if (sbd_tb_pkg::home_slot_of(cand, CAPACITY) == CAPACITY - 1) begin
            wrap_vals = {wrap_vals, cand};
         end
         cand++;
      end
      cand = 32'd2;
      while (sbd_tb_pkg::home_slot_of(cand, CAPACITY) != 0) cand++;
      head_val = cand;

      directed = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001,
                   32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      directed = {directed, wrap_vals[0], wrap_vals[1], wrap_vals[2], head_val,
                  wrap_vals[2], wrap_vals[1], wrap_vals[0], head_val, wrap_vals[2]};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_value(directed[i]);

      // mostly fresh values until the table fills, then many repeats
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= 300 && n < 600);
         rep_pct = (offered.num() >= CAPACITY) ? 40 : 6;
         r = $urandom_range(0, 99);
         if (r < rep_pct) begin
            pick = history[$urandom_range(0, history.size() - 1)];
         end else if (r < rep_pct + 4) begin
            case ($urandom_range(0, 2))
               0: pick = 32'h1 << $urandom_range(0, 31);
               1: pick = ~(32'h1 << $urandom_range(0, 31));
               default: pick = $urandom_range(0, 31) - 16;
            endcase
         end else begin
            pick = $urandom;
         end
         send_value(pick);
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);

      $display("Run covered %0d transactions over %0d distinct values into %0d slots.",
               answers, offered.num(), CAPACITY);
      $display("Repeats flagged: %0d; new values turned away by a full table: %0d.",
               repeats, rejections);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
design/sbd_pkg.sv
design/sbd_ram.sv
design/sbd_hash.sv
design/seen_before_detector_unit.sv
design/sbd_checker.sv
verif/seen_before_checker.sv
verif/tb_seen_before_detector_unit.sv
